### design/udsn_pkg.sv
// shared types and constants of the url path dot-segment normaliser
package udsn_pkg;

  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;

  localparam logic OP_PATH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] path_byte;
    logic       last_byte;
    logic [9:0] read_index;
  } udsn_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [10:0] norm_length;
    logic [6:0]  seg_depth;
    logic        overflow;
    logic        done_res;
  } udsn_rsp_t;

endpackage

### design/udsn_ram.sv
// generic single-port-write ram with registered read
module udsn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/url_path_dot_segment_normalizer_unit.sv
// top level of the url path dot-segment normaliser
//
// Takes a url path one byte per beat, with last_byte on the final byte, and
// builds the normalised path: the first byte of each path is skipped and
// stands for the leading slash, empty and "." segments vanish, ".." drops
// the last kept segment (staying at root), and every other segment is kept
// as '/' plus its bytes. Each path beat returns the running length, the
// segment depth, a sticky overflow flag and done; a read beat returns one
// byte of the normalised path by index (zero at or beyond the length) and
// changes nothing. One beat is taken every clock cycle while the result side
// is not stalled; its result goes through the registered read of the path
// buffer ram and then the output register. The path buffer and the
// segment-start stack both live in rams with no reset and no clearing pass;
// only positions below the current length are ever returned.
module url_path_dot_segment_normalizer_unit
  import udsn_pkg::*;
#(
  parameter int MAX_PATH_BYTES = 1024,
  parameter int MAX_SEGMENTS   = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  udsn_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output udsn_rsp_t rsp
);

  localparam int AW = $clog2(MAX_PATH_BYTES);     // buffer address
  localparam int PW = $clog2(MAX_PATH_BYTES + 1); // write pointer
  localparam int SW = $clog2(MAX_SEGMENTS);       // stack address
  localparam int DW = $clog2(MAX_SEGMENTS + 1);   // stack depth
  localparam int CW = (PW + 1 > 11) ? PW + 1 : 11; // compare width
  localparam int XW = (AW > 10) ? AW : 10;
  localparam int EW = (DW > 7) ? DW : 7;

  localparam logic [CW-1:0] MAX_C   = CW'(MAX_PATH_BYTES);
  localparam logic [DW-1:0] MAXSEG_C = DW'(MAX_SEGMENTS);
  // open segment length: none, one, two, three or more
  localparam logic [1:0] SEG_NONE = 2'd0;
  localparam logic [1:0] SEG_ONE  = 2'd1;
  localparam logic [1:0] SEG_TWO  = 2'd2;
  localparam logic [1:0] SEG_LONG = 2'd3;

  // path state
  logic          skip, skip_next;
  logic          ovf, ovf_next;
  logic          done, done_next;
  logic [PW-1:0] wptr, wptr_next;
  logic [DW-1:0] depth, depth_next;
  logic [1:0]    seg_cnt, seg_cnt_next;
  logic          dot0, dot0_next;
  logic          dot1, dot1_next;
  logic [PW-1:0] seg_base, seg_base_next;
  // cached top of the stack, refilled from the stack ram after a pop
  logic [AW-1:0] tos, tos_next;
  logic          refill;

  // ram ports
  logic          buf_we, buf_re;
  logic [AW-1:0] buf_waddr, buf_raddr;
  logic [7:0]    buf_wdata, buf_rdata;
  logic          stk_we, stk_re;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [AW-1:0] stk_wdata, stk_rdata;

  // pipeline
  logic          accept, s1_adv;
  logic          s1_valid;
  logic          s1_rd_sel;
  logic [10:0]   s1_len;
  logic [6:0]    s1_depth;
  logic          s1_ovf, s1_done;
  logic          rd_sel;
  logic [XW-1:0] ridx_x;
  logic [CW-1:0] len_x;
  logic [EW-1:0] depth_x;
  logic          pop_read;

  assign s1_adv    = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || s1_adv;
  assign accept    = req_valid && req_ready;

  // read beats: the buffer ram is read straight from the beat
  assign ridx_x    = XW'(req.read_index);
  assign buf_raddr = ridx_x[AW-1:0];
  assign buf_re    = accept && (req.opcode == OP_READ);
  assign rd_sel    = (req.opcode == OP_READ) && (CW'(req.read_index) < CW'(wptr))
                     && (CW'(req.read_index) < MAX_C);

  always_comb begin
    logic [PW-1:0] base_eff;
    logic [AW-1:0] tos_eff;
    logic          is_slash;
    logic          is_dot;
    logic [1:0]    cnt_inc;
    logic [CW-1:0] pos;
    logic [CW-1:0] keep_end;
    logic [DW-1:0] dm2;
    logic          do_close;
    logic          close_slash;
    logic [1:0]    close_len;
    logic          close_d0;
    logic          close_d1;

    skip_next     = skip;
    ovf_next      = ovf;
    done_next     = done;
    wptr_next     = wptr;
    depth_next    = depth;
    seg_cnt_next  = seg_cnt;
    dot0_next     = dot0;
    dot1_next     = dot1;
    seg_base_next = seg_base;
    buf_we        = 1'b0;
    buf_waddr     = '0;
    buf_wdata     = CHAR_SLASH;
    stk_we        = 1'b0;
    stk_waddr     = depth[SW-1:0];
    stk_re        = 1'b0;
    stk_raddr     = '0;
    pop_read      = 1'b0;

    base_eff = (seg_cnt == SEG_NONE) ? wptr : seg_base;
    tos_eff  = refill ? stk_rdata : tos;
    stk_wdata = base_eff[AW-1:0];
    is_slash = (req.path_byte == CHAR_SLASH);
    is_dot   = (req.path_byte == CHAR_DOT);
    cnt_inc  = (seg_cnt == SEG_LONG) ? SEG_LONG : seg_cnt + 2'd1;
    // '/' sits at the segment base, byte k of the segment at base + k
    pos      = (seg_cnt == SEG_LONG) ? CW'(wptr) : CW'(wptr) + CW'(cnt_inc);
    dm2      = depth - DW'(2);
    keep_end = '0;

    do_close    = 1'b0;
    close_slash = 1'b0;
    close_len   = seg_cnt;
    close_d0    = dot0;
    close_d1    = dot1;

    if (accept && (req.opcode == OP_PATH)) begin
      if (skip) begin
        // first byte of a new path: reset and plant the leading slash
        skip_next    = req.last_byte;
        done_next    = req.last_byte;
        ovf_next     = 1'b0;
        wptr_next    = '0;
        depth_next   = '0;
        seg_cnt_next = SEG_NONE;
        buf_we       = 1'b1;
        buf_waddr    = '0;
        buf_wdata    = CHAR_SLASH;
      end else begin
        if (!ovf) begin
          if (is_slash) begin
            do_close    = 1'b1;
            close_slash = 1'b1;
          end else begin
            seg_cnt_next = cnt_inc;
            if (seg_cnt == SEG_NONE) begin
              seg_base_next = wptr;
              dot0_next     = is_dot;
            end
            if (seg_cnt == SEG_ONE) begin
              dot1_next = is_dot;
            end
            buf_waddr = pos[AW-1:0];
            buf_wdata = req.path_byte;
            if (cnt_inc == SEG_LONG) begin
              // segment is now known to be kept, bytes count in the length
              if (pos >= MAX_C) begin
                ovf_next  = 1'b1;
                wptr_next = base_eff;
              end else begin
                wptr_next = PW'(pos + CW'(1));
                buf_we    = 1'b1;
              end
            end else begin
              // held bytes are stored early, beyond the visible length
              buf_we = (pos < MAX_C);
            end
            if (req.last_byte) begin
              do_close  = 1'b1;
              close_len = cnt_inc;
              close_d0  = (seg_cnt == SEG_NONE) ? is_dot : dot0;
              close_d1  = (seg_cnt == SEG_ONE) ? is_dot : dot1;
            end
          end
        end
        if (req.last_byte) begin
          done_next = 1'b1;
          skip_next = 1'b1;
        end
      end
    end

    if (do_close) begin
      seg_cnt_next = SEG_NONE;
      if ((close_len != SEG_NONE) && !ovf_next) begin
        if ((close_len == SEG_ONE) && close_d0) begin
          // single dot segment: dropped
        end else if ((close_len == SEG_TWO) && close_d0 && close_d1) begin
          // dot-dot: back to the start of the last kept segment
          if (depth != '0) begin
            depth_next = depth - DW'(1);
            wptr_next  = PW'(tos_eff);
            if (depth >= DW'(2)) begin
              stk_re    = 1'b1;
              stk_raddr = dm2[SW-1:0];
              pop_read  = 1'b1;
            end
          end
        end else begin
          keep_end = (close_len == SEG_LONG) ? CW'(wptr_next)
                   : CW'(base_eff) + CW'(close_len) + CW'(1);
          if ((close_len != SEG_LONG) && (keep_end > MAX_C)) begin
            ovf_next  = 1'b1;
            wptr_next = base_eff;
          end else if (depth >= MAXSEG_C) begin
            ovf_next  = 1'b1;
            wptr_next = base_eff;
          end else begin
            stk_we     = 1'b1;
            depth_next = depth + DW'(1);
            wptr_next  = PW'(keep_end);
            // slash of the next segment goes in now
            if (close_slash && (keep_end < MAX_C)) begin
              buf_we    = 1'b1;
              buf_waddr = keep_end[AW-1:0];
              buf_wdata = CHAR_SLASH;
            end
          end
        end
      end
    end

    tos_next = stk_we ? base_eff[AW-1:0] : tos_eff;
  end

  assign len_x   = CW'(wptr_next);
  assign depth_x = EW'(depth_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      skip     <= 1'b1;
      ovf      <= 1'b0;
      done     <= 1'b0;
      wptr     <= '0;
      depth    <= '0;
      seg_cnt  <= SEG_NONE;
      refill   <= 1'b0;
      s1_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      skip    <= skip_next;
      ovf     <= ovf_next;
      done    <= done_next;
      wptr    <= wptr_next;
      depth   <= depth_next;
      seg_cnt <= seg_cnt_next;
      refill  <= pop_read;
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      if (s1_adv) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dot0     <= dot0_next;
    dot1     <= dot1_next;
    seg_base <= seg_base_next;
    tos      <= tos_next;
    if (accept) begin
      s1_rd_sel <= rd_sel;
      s1_len    <= len_x[10:0];
      s1_depth  <= depth_x[6:0];
      s1_ovf    <= ovf_next;
      s1_done   <= done_next;
    end
    if (s1_adv && s1_valid) begin
      rsp.read_data   <= s1_rd_sel ? buf_rdata : 8'h00;
      rsp.norm_length <= s1_len;
      rsp.seg_depth   <= s1_depth;
      rsp.overflow    <= s1_ovf;
      rsp.done_res    <= s1_done;
    end
  end

  udsn_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PATH_BYTES)
  ) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  udsn_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_SEGMENTS)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

### design/udsn_checker.sv
// port-level checks of the normaliser and their bind
module udsn_checker
  import udsn_pkg::*;
#(
  parameter int MAX_PATH_BYTES = 1024,
  parameter int MAX_SEGMENTS   = 64
) (
  input logic      clk,
  input logic      rst,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input udsn_rsp_t rsp
);

  // length and depth fields wrap only for very large limits
  localparam bit NARROW = (MAX_PATH_BYTES < 2048) && (MAX_SEGMENTS < 128);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result beat straight after reset");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !NARROW || (rsp.norm_length <= 11'(MAX_PATH_BYTES)))
    else $error("normalised length beyond buffer size");

  a_data_in_path: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.read_data != 8'h00) |-> !NARROW || (rsp.norm_length != 11'd0))
    else $error("non-zero byte read from an empty path");

  a_depth_vs_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !NARROW || ((12'(rsp.seg_depth) << 1) <= 12'(rsp.norm_length)))
    else $error("more segments than the length can hold");

endmodule

bind url_path_dot_segment_normalizer_unit udsn_checker #(
  .MAX_PATH_BYTES (MAX_PATH_BYTES),
  .MAX_SEGMENTS   (MAX_SEGMENTS)
) u_udsn_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

### tb/sv/tb_url_path_dot_segment_normalizer_unit.sv
// testbench of the url path dot-segment normaliser with a built-in predictor
`timescale 1ns / 1ps
module tb_url_path_dot_segment_normalizer_unit;
  import udsn_pkg::*;

  localparam int PATH_CAP     = 1024;
  localparam int SEG_CAP      = 64;
  localparam int IDLE_LIMIT   = 4000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 8;     // margin for the last results to drain

  typedef logic [7:0] byte_q_t[$];

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  udsn_req_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  udsn_rsp_t rsp;

  always #2 clk = ~clk;

  url_path_dot_segment_normalizer_unit #(
    .MAX_PATH_BYTES(PATH_CAP),
    .MAX_SEGMENTS  (SEG_CAP)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // ---------------------------------------------------------------------------
  // predictor state: normalised path buffer, stack of segment starts and the
  // open segment, whose first two bytes are held back until we know the
  // segment is neither "." nor ".."
  // ---------------------------------------------------------------------------
  logic [7:0]  norm_bytes [PATH_CAP];
  logic [10:0] seg_starts [SEG_CAP];
  int          depth_now;
  int          wr_ptr;
  int          seg_start;
  int          seg_len;
  logic [15:0] held_pair;
  bit          awaiting_first = 1'b1;
  bit          too_long;
  bit          path_complete;

  udsn_rsp_t   pending_results[$];
  udsn_rsp_t   oldest_result;
  int          error_count;
  bit          no_gaps;
  int          stall_left;
  int          idle_cycles;

  // append one byte to the normalised path; running off the end of the
  // buffer throws away the open segment and marks the path as too long
  function automatic void put_byte(input logic [7:0] c);
    if (too_long) return;
    if (wr_ptr >= PATH_CAP) begin
      too_long = 1'b1;
      wr_ptr   = seg_start;
      seg_len  = 0;
      return;
    end
    norm_bytes[wr_ptr] = c;
    wr_ptr++;
  endfunction

  // the open segment turned out to be a real name: write '/' and the held bytes
  function automatic void flush_held(input int held);
    seg_start = wr_ptr;
    put_byte(CHAR_SLASH);
    put_byte(held_pair[15:8]);
    if (held > 1) put_byte(held_pair[7:0]);
  endfunction

  // end of a segment: drop empty and ".", pop on "..", otherwise push it
  function automatic void close_segment();
    int n;
    n       = seg_len;
    seg_len = 0;
    if (n == 0 || too_long) return;
    if (n == 1 && held_pair[15:8] == CHAR_DOT) return;
    if (n == 2 && held_pair == {CHAR_DOT, CHAR_DOT}) begin
      // at root a ".." simply stays at root
      if (depth_now > 0) begin
        depth_now--;
        wr_ptr = seg_starts[depth_now];
      end
      return;
    end
    if (n <= 2) flush_held(n);
    if (too_long) return;
    if (depth_now >= SEG_CAP) begin
      // stack full: the segment just written is discarded
      too_long = 1'b1;
      wr_ptr   = seg_start;
      return;
    end
    seg_starts[depth_now] = 11'(seg_start);
    depth_now++;
  endfunction

  function automatic void take_path_byte(input logic [7:0] c);
    if (too_long) return;
    if (c == CHAR_SLASH) begin
      close_segment();
      return;
    end
    if (seg_len < 'h7ff) seg_len++;
    if (seg_len == 1) begin
      held_pair = {c, 8'h00};
    end else if (seg_len == 2) begin
      held_pair[7:0] = c;
    end else if (seg_len == 3) begin
      flush_held(2);
      put_byte(c);
    end else begin
      put_byte(c);
    end
  endfunction

  // expected result of one accepted beat, advancing the predictor state
  function automatic udsn_rsp_t normalise_step(input udsn_req_t r);
    udsn_rsp_t e;
    e = '0;
    if (r.opcode == OP_READ) begin
      // reads change nothing; at or beyond the length they give zero
      if (int'(r.read_index) < wr_ptr) e.read_data = norm_bytes[r.read_index];
    end else if (awaiting_first) begin
      // skipped first byte of a new path: start from an empty path
      awaiting_first = 1'b0;
      depth_now      = 0;
      wr_ptr         = 0;
      seg_start      = 0;
      seg_len        = 0;
      held_pair      = '0;
      too_long       = 1'b0;
      path_complete  = 1'b0;
      if (r.last_byte) begin
        path_complete  = 1'b1;
        awaiting_first = 1'b1;
      end
    end else begin
      take_path_byte(r.path_byte);
      if (r.last_byte) begin
        close_segment();
        seg_len        = 0;
        path_complete  = 1'b1;
        awaiting_first = 1'b1;
      end
    end
    e.norm_length = 11'(wr_ptr);
    e.seg_depth   = 7'(depth_now);
    e.overflow    = too_long;
    e.done_res    = path_complete;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // idling: mostly no gap or a short one, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // read index mostly around the current length, sometimes anywhere
  function automatic int pick_read_index();
    int hi;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, PATH_CAP - 1);
    hi = (wr_ptr + 1 > PATH_CAP - 1) ? PATH_CAP - 1 : wr_ptr + 1;
    return $urandom_range(0, hi);
  endfunction

  // segment byte: plenty of dots so that ".x", "..y" and "..." turn up
  function automatic logic [7:0] pick_name_char();
    int roll;
    int c;
    roll = $urandom_range(0, 9);
    if (roll < 3) return CHAR_DOT;
    if (roll < 8) return 8'($urandom_range(8'h61, 8'h7a));
    c = $urandom_range(0, 254);
    if (c >= CHAR_SLASH) c++;
    return 8'(c);
  endfunction

  function automatic byte_q_t make_name(input int len);
    byte_q_t q;
    for (int i = 0; i < len; i++) q.push_back(pick_name_char());
    return q;
  endfunction

  // well-formed random path: skipped lead byte, then empty, ".", ".." and
  // ordinary segments, sometimes with a trailing slash
  function automatic byte_q_t make_path(input int max_segs);
    byte_q_t p;
    byte_q_t name;
    int nseg;
    int kind;
    p.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : CHAR_SLASH);
    nseg = $urandom_range(0, max_segs);
    for (int s = 0; s < nseg; s++) begin
      if (s > 0) p.push_back(CHAR_SLASH);
      kind = $urandom_range(0, 9);
      case (kind)
        0: ;
        1: p.push_back(CHAR_DOT);
        2, 3: begin
          p.push_back(CHAR_DOT);
          p.push_back(CHAR_DOT);
        end
        default: begin
          name = make_name($urandom_range(1, 6));
          p = {p, name};
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) p.push_back(CHAR_SLASH);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one request beat; valid is only dropped when a gap is taken, so a
  // back-to-back beat never sees valid lowered and raised in one step
  task automatic send_beat(input udsn_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_results.push_back(normalise_step(r));
  endtask

  task automatic send_path_byte(input logic [7:0] c, input bit is_last);
    udsn_req_t r;
    r.opcode     = OP_PATH;
    r.path_byte  = c;
    r.last_byte  = is_last;
    r.read_index = 10'($urandom);
    send_beat(r);
  endtask

  task automatic send_read(input int idx);
    udsn_req_t r;
    r.opcode     = OP_READ;
    r.path_byte  = 8'($urandom);
    r.last_byte  = 1'($urandom);
    r.read_index = 10'(idx);
    send_beat(r);
  endtask

  // whole path with last_byte on the final byte, reads mixed in at random
  task automatic send_path(input byte_q_t p, input int read_pct);
    for (int i = 0; i < p.size(); i++) begin
      if ($urandom_range(0, 99) < read_pct) send_read(pick_read_index());
      send_path_byte(p[i], i == p.size() - 1);
    end
    if (read_pct > 0) begin
      repeat ($urandom_range(1, 4)) send_read(pick_read_index());
    end
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic wait_for_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // response side: random stalls and checking against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp.read_data !== oldest_result.read_data)
          report_mismatch($sformatf("read_data got %0d expected %0d",
                                    rsp.read_data, oldest_result.read_data));
        if (rsp.norm_length !== oldest_result.norm_length)
          report_mismatch($sformatf("norm_length got %0d expected %0d",
                                    rsp.norm_length, oldest_result.norm_length));
        if (rsp.seg_depth !== oldest_result.seg_depth)
          report_mismatch($sformatf("seg_depth got %0d expected %0d",
                                    rsp.seg_depth, oldest_result.seg_depth));
        if (rsp.overflow !== oldest_result.overflow)
          report_mismatch($sformatf("overflow got %0d expected %0d",
                                    rsp.overflow, oldest_result.overflow));
        if (rsp.done_res !== oldest_result.done_res)
          report_mismatch($sformatf("done_res got %0d expected %0d",
                                    rsp.done_res, oldest_result.done_res));
      end
    end
    // receiver back-pressure
    if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // watchdog: ends the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, both opcodes and the dot-segment cases in a few short paths
  task automatic test_directed();
    byte_q_t p;
    // reads before any path has been seen: empty buffer
    send_read(0);
    send_read(PATH_CAP - 1);
    // a path made of its skipped byte alone is empty and done at once
    send_path_byte(8'hff, 1'b1);
    // kept segment, ".", ".." popping it, empty segment, ".." at root,
    // a name with the byte extremes, trailing slash
    p = {CHAR_SLASH, 8'h61, 8'h62, CHAR_SLASH, CHAR_DOT, CHAR_SLASH,
         CHAR_DOT, CHAR_DOT, CHAR_SLASH, CHAR_SLASH, CHAR_DOT, CHAR_DOT,
         CHAR_SLASH, 8'hff, 8'h00, CHAR_DOT, CHAR_SLASH};
    send_path(p, 0);
    // last byte of the normalised path and the first position beyond it
    send_read(3);
    send_read(4);
    // two-byte name starting with a dot, closed by the last byte
    p = {CHAR_SLASH, CHAR_DOT, 8'h78};
    send_path(p, 0);
  endtask

  task automatic test_random_paths(input int n_paths);
    for (int i = 0; i < n_paths; i++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      send_path(make_path(10), 15);
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end
    no_gaps = 1'b0;
  endtask

  // more than the stack can hold, then ".." and bytes that must be ignored
  task automatic test_stack_full();
    byte_q_t p;
    byte_q_t name;
    p.push_back(CHAR_SLASH);
    repeat ($urandom_range(SEG_CAP + 2, SEG_CAP + 8)) begin
      repeat ($urandom_range(1, 3)) p.push_back(8'($urandom_range(8'h61, 8'h7a)));
      p.push_back(CHAR_SLASH);
    end
    p = {p, CHAR_DOT, CHAR_DOT, CHAR_SLASH};
    name = make_name(4);
    p = {p, name};
    send_path(p, 5);
  endtask

  // long names until the buffer runs out, then ignored bytes after it
  task automatic test_buffer_full();
    byte_q_t p;
    p.push_back(CHAR_SLASH);
    while (p.size() < PATH_CAP + 40) begin
      repeat ($urandom_range(1, 60)) p.push_back(8'($urandom_range(8'h61, 8'h7a)));
      p.push_back(CHAR_SLASH);
    end
    p = {p, CHAR_DOT, CHAR_DOT, CHAR_SLASH, CHAR_DOT, CHAR_DOT};
    send_path(p, 2);
    send_read(PATH_CAP - 1);
    send_read(pick_read_index());
  endtask

  // unstructured beats: random opcodes, bytes and last flags
  task automatic test_noise(input int n_beats);
    udsn_req_t r;
    int roll;
    repeat (n_beats) begin
      r.opcode     = ($urandom_range(0, 9) < 3) ? OP_READ : OP_PATH;
      roll         = $urandom_range(0, 9);
      r.path_byte  = (roll < 2) ? CHAR_SLASH : (roll < 4) ? CHAR_DOT : 8'($urandom);
      r.last_byte  = ($urandom_range(0, 9) == 0);
      r.read_index = 10'(pick_read_index());
      send_beat(r);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    wait_for_results();
    test_random_paths(15);
    test_stack_full();
    wait_for_results();
    test_buffer_full();
    test_random_paths(15);
    test_noise(150);

    // all stimulus is in: let the last results drain
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
